@@ sv/sci_pkg.sv @@
// Shared types and constants of the spectrometer clear/integrate sequencer.
package sci_pkg;

   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_EOS   = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   localparam logic [1:0] CODE_EMPTY = 2'd0;
   localparam logic [1:0] CODE_ACQ   = 2'd1;
   localparam logic [1:0] CODE_CLEAR = 2'd2;
   localparam logic [1:0] CODE_UNDEF = 2'd3;

   localparam logic PULSE_CLEAR = 1'b0;
   localparam logic PULSE_ACQ   = 1'b1;

   localparam logic [1:0] REG_AUTO_CLEARING   = 2'd0;
   localparam logic [1:0] REG_CHANNEL_ENABLED = 2'd1;
   localparam logic [1:0] REG_MIN_TICKS       = 2'd2;
   localparam logic [1:0] REG_MAX_TICKS       = 2'd3;

   localparam logic [15:0] MIN_TICKS_RESET    = 16'd1;
   localparam logic [15:0] MAX_TICKS_RESET    = 16'hFFFF;
   localparam logic [15:0] TIMER_RELOAD_RESET = 16'd1;

   typedef enum logic [1:0] {
      KIND_UNDEF = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_ACQ   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      OP_START_OK  = 3'd0,
      OP_START_REJ = 3'd1,
      OP_EOS       = 3'd2,
      OP_TICK      = 3'd3,
      OP_READ      = 3'd4
   } op_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] integration_ticks;
      logic [3:0]  clearout_count;
      logic [3:0]  readout_count;
      logic [3:0]  log_index;
   } req_data_type;

   typedef struct packed {
      logic        status;
      logic        start_pulse;
      logic        pulse_kind;
      logic        spectrum_done;
      logic        clearout_done;
      logic        integrating;
      logic [15:0] eos_total;
      logic [1:0]  log_code;
      logic [3:0]  clearouts_left;
      logic [3:0]  readouts_left;
   } rsp_data_type;

   typedef struct packed {
      logic        auto_clearing;
      logic        channel_enabled;
      logic [15:0] min_ticks;
      logic [15:0] max_ticks;
   } cfg_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] ticks;
      logic [3:0]  clearouts;
      logic [3:0]  readouts;
      logic [3:0]  log_index;
   } cmd_type;

endpackage

@@ sv/sci_front.sv @@
// Front end: accepts requests, checks start limits and clamps the scan counts.
module sci_front #(
   parameter int MAX_SCANS = 15
) (
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sci_pkg::req_data_type req_data,
   input  sci_pkg::cfg_type     cfg,
   input  logic                 q_full,
   output logic                 push,
   output sci_pkg::cmd_type     cmd
);

   localparam int SW = $clog2(MAX_SCANS + 1);
   localparam int CW = (SW > 4) ? SW : 4;
   localparam logic [CW-1:0] SCANS = CW'(MAX_SCANS);

   logic [CW-1:0] ncl_raw;
   logic [CW-1:0] ncl_c;
   logic [CW-1:0] nrd_raw;
   logic [CW-1:0] nrd_c;
   logic [CW-1:0] room;
   logic          start_ok;

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   always_comb begin
      ncl_raw = CW'(req_data.clearout_count);
      if (ncl_raw == '0) begin
         ncl_c = CW'(1);
      end else if (ncl_raw > SCANS) begin
         ncl_c = SCANS;
      end else begin
         ncl_c = ncl_raw;
      end
      room    = SCANS - ncl_c;
      nrd_raw = CW'(req_data.readout_count);
      nrd_c   = (nrd_raw > room) ? room : nrd_raw;

      start_ok = cfg.channel_enabled &&
                 (cfg.min_ticks < req_data.integration_ticks) &&
                 (req_data.integration_ticks < cfg.max_ticks);

      cmd.ticks     = req_data.integration_ticks;
      cmd.clearouts = 4'(ncl_c - CW'(1));
      cmd.readouts  = 4'(nrd_c);
      cmd.log_index = req_data.log_index;

      unique case (req_data.req_type)
         sci_pkg::REQ_START: cmd.op = start_ok ? sci_pkg::OP_START_OK : sci_pkg::OP_START_REJ;
         sci_pkg::REQ_EOS:   cmd.op = sci_pkg::OP_EOS;
         sci_pkg::REQ_TICK:  cmd.op = sci_pkg::OP_TICK;
         default:            cmd.op = sci_pkg::OP_READ;
      endcase
   end

endmodule

@@ sv/sci_queue.sv @@
// Two-entry command queue between the front end and the execution back end.
module sci_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sci_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             q_valid,
   output logic             q_full,
   output sci_pkg::cmd_type head
);

   sci_pkg::cmd_type slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   assign q_valid = (count_ff != 2'd0);
   assign q_full  = (count_ff == 2'd2);
   assign head    = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? !wptr_ff : wptr_ff;
      rptr_in  = pop ? !rptr_ff : rptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid) else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != 2'd3) && ((wptr_ff == rptr_ff) == (count_ff != 2'd1)))
      else $error("queue pointers and count disagree");

endmodule

@@ sv/sci_back.sv @@
// Back end: sequencer state, integration timer, EOS log and result register.
module sci_back #(
   parameter int LOG_DEPTH = 16,
   parameter int MAX_SCANS = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  auto_clearing,
   input  logic                  q_valid,
   input  sci_pkg::cmd_type      cmd,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sci_pkg::rsp_data_type rsp_data
);

   localparam int LOG_AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int IW     = (LOG_AW > 4) ? LOG_AW : 4;
   localparam logic [15:0] LOG_LIMIT = 16'(LOG_DEPTH);

   logic [3:0]       pend_cl_ff, pend_cl_in;
   logic [3:0]       pend_rd_ff, pend_rd_in;
   sci_pkg::kind_type last_kind_ff, last_kind_in;
   logic [15:0]      eos_cnt_ff, eos_cnt_in;
   logic             wrapped_ff, wrapped_in;
   logic [15:0]      reload_ff, reload_in;
   logic [15:0]      tcnt_ff, tcnt_in;
   logic             running_ff, running_in;

   logic             rsp_valid_ff, rsp_valid_in;
   sci_pkg::rsp_data_type rsp_ff, rsp_in;
   logic             hit_ff, hit_in;
   logic [1:0]       rd_data_ff;

   logic [1:0]       log_mem [LOG_DEPTH];
   logic             log_we;
   logic [1:0]       log_wdata;
   logic [LOG_AW-1:0] log_waddr;
   logic [LOG_AW-1:0] log_raddr;
   logic [IW-1:0]    idx_w;

   assign pop       = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign idx_w     = IW'(cmd.log_index);
   assign log_raddr = idx_w[LOG_AW-1:0];
   assign log_waddr = eos_cnt_ff[LOG_AW-1:0];

   always_comb begin
      rsp_data          = rsp_ff;
      rsp_data.log_code = hit_ff ? rd_data_ff : sci_pkg::CODE_EMPTY;
   end

   always_comb begin
      pend_cl_in   = pend_cl_ff;
      pend_rd_in   = pend_rd_ff;
      last_kind_in = last_kind_ff;
      eos_cnt_in   = eos_cnt_ff;
      wrapped_in   = wrapped_ff;
      reload_in    = reload_ff;
      tcnt_in      = tcnt_ff;
      running_in   = running_ff;
      rsp_in       = '0;
      hit_in       = 1'b0;
      log_we       = 1'b0;
      log_wdata    = sci_pkg::CODE_UNDEF;

      if (pop) begin
         unique case (cmd.op)
            sci_pkg::OP_START_REJ: begin
               rsp_in.status = 1'b1;
            end
            sci_pkg::OP_START_OK: begin
               running_in = 1'b0;
               reload_in  = cmd.ticks;
               pend_cl_in = cmd.clearouts;
               pend_rd_in = cmd.readouts;
               eos_cnt_in = '0;
               wrapped_in = 1'b0;
               if (!auto_clearing) begin
                  rsp_in.start_pulse = 1'b1;
                  rsp_in.pulse_kind  = sci_pkg::PULSE_CLEAR;
                  last_kind_in       = sci_pkg::KIND_CLEAR;
               end
            end
            sci_pkg::OP_EOS: begin
               case (last_kind_ff)
                  sci_pkg::KIND_ACQ: begin
                     log_wdata            = sci_pkg::CODE_ACQ;
                     rsp_in.spectrum_done = 1'b1;
                  end
                  sci_pkg::KIND_CLEAR: begin
                     log_wdata            = sci_pkg::CODE_CLEAR;
                     rsp_in.clearout_done = 1'b1;
                  end
                  default: log_wdata = sci_pkg::CODE_UNDEF;
               endcase
               log_we     = (eos_cnt_ff < LOG_LIMIT);
               eos_cnt_in = eos_cnt_ff + 16'd1;
               if (eos_cnt_ff == '1) begin
                  wrapped_in = 1'b1;
               end
               if ((pend_cl_ff != 4'd0) || (pend_rd_ff == 4'd0)) begin
                  if (pend_cl_ff != 4'd0) begin
                     pend_cl_in         = pend_cl_ff - 4'd1;
                     rsp_in.start_pulse = 1'b1;
                     rsp_in.pulse_kind  = sci_pkg::PULSE_CLEAR;
                     last_kind_in       = sci_pkg::KIND_CLEAR;
                  end else if (auto_clearing) begin
                     rsp_in.start_pulse = 1'b1;
                     rsp_in.pulse_kind  = sci_pkg::PULSE_CLEAR;
                     last_kind_in       = sci_pkg::KIND_CLEAR;
                  end else begin
                     last_kind_in = sci_pkg::KIND_UNDEF;
                  end
               end else begin
                  tcnt_in    = '0;
                  running_in = 1'b1;
                  pend_rd_in = pend_rd_ff - 4'd1;
               end
            end
            sci_pkg::OP_TICK: begin
               if (running_ff) begin
                  tcnt_in = tcnt_ff + 16'd1;
                  if (tcnt_in == reload_ff) begin
                     running_in         = 1'b0;
                     rsp_in.start_pulse = 1'b1;
                     rsp_in.pulse_kind  = sci_pkg::PULSE_ACQ;
                     last_kind_in       = sci_pkg::KIND_ACQ;
                  end
               end
            end
            default: begin
               hit_in = (16'(cmd.log_index) < LOG_LIMIT) &&
                        (wrapped_ff || (16'(cmd.log_index) < eos_cnt_ff));
            end
         endcase
         rsp_in.integrating    = running_in;
         rsp_in.eos_total      = eos_cnt_in;
         rsp_in.clearouts_left = pend_cl_in;
         rsp_in.readouts_left  = pend_rd_in;
      end

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cl_ff   <= 4'd0;
         pend_rd_ff   <= 4'd0;
         last_kind_ff <= sci_pkg::KIND_UNDEF;
         eos_cnt_ff   <= 16'd0;
         wrapped_ff   <= 1'b0;
         reload_ff    <= sci_pkg::TIMER_RELOAD_RESET;
         tcnt_ff      <= 16'd0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_cl_ff   <= pend_cl_in;
         pend_rd_ff   <= pend_rd_in;
         last_kind_ff <= last_kind_in;
         eos_cnt_ff   <= eos_cnt_in;
         wrapped_ff   <= wrapped_in;
         reload_ff    <= reload_in;
         tcnt_ff      <= tcnt_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (log_we) begin
         log_mem[log_waddr] <= log_wdata;
      end
      if (pop) begin
         rd_data_ff <= log_mem[log_raddr];
      end
   end

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      (9'(pend_cl_ff) + 9'(pend_rd_ff)) < 9'(MAX_SCANS))
      else $error("pending scan counts exceed limit");
   a_done_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.spectrum_done && rsp_ff.clearout_done))
      else $error("EOS classified twice");
   a_acq_stops_timer: assert property (@(posedge clock) disable iff (reset)
      (pop && (cmd.op == sci_pkg::OP_TICK) && (tcnt_in == reload_ff) && running_ff)
      |=> (!running_ff && (last_kind_ff == sci_pkg::KIND_ACQ)))
      else $error("timer expiry did not stop timer");

endmodule

@@ sv/spectrometer_clear_integrate_sequencer_core.sv @@
// Top level of the spectrometer clear/integrate sequencer with its register port.
// Takes one request per clock while req_stall is low and returns one result
// per request, in order. A request is classified in the cycle it is transferred
// and lands in a two-entry queue; the back end executes one queued command per
// clock into the result register unless rsp_stall holds it. The EOS log is a
// LOG_DEPTH-entry memory with a registered read; entries are tracked by the
// EOS count, so no clearing pass is needed after reset or a start. Registers
// sit at byte offsets 0x0 auto_clearing, 0x4 channel_enabled, 0x8 min_ticks,
// 0xC max_ticks; the user must write them only while no request is in flight,
// and the block itself does not enforce this.
module spectrometer_clear_integrate_sequencer_core #(
   parameter int LOG_DEPTH = 16,
   parameter int MAX_SCANS = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sci_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sci_pkg::rsp_data_type rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   sci_pkg::cfg_type cfg_ff, cfg_in;
   logic             csr_write;
   logic             push;
   logic             pop;
   logic             q_valid;
   logic             q_full;
   sci_pkg::cmd_type push_cmd;
   sci_pkg::cmd_type head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (paddr[3:2])
            sci_pkg::REG_AUTO_CLEARING:   cfg_in.auto_clearing   = pwdata[0];
            sci_pkg::REG_CHANNEL_ENABLED: cfg_in.channel_enabled = pwdata[0];
            sci_pkg::REG_MIN_TICKS:       cfg_in.min_ticks       = pwdata[15:0];
            default:                      cfg_in.max_ticks       = pwdata[15:0];
         endcase
      end
      unique case (paddr[3:2])
         sci_pkg::REG_AUTO_CLEARING:   prdata = {31'd0, cfg_ff.auto_clearing};
         sci_pkg::REG_CHANNEL_ENABLED: prdata = {31'd0, cfg_ff.channel_enabled};
         sci_pkg::REG_MIN_TICKS:       prdata = {16'd0, cfg_ff.min_ticks};
         default:                      prdata = {16'd0, cfg_ff.max_ticks};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_clearing   <= 1'b0;
         cfg_ff.channel_enabled <= 1'b0;
         cfg_ff.min_ticks       <= sci_pkg::MIN_TICKS_RESET;
         cfg_ff.max_ticks       <= sci_pkg::MAX_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sci_front #(
      .MAX_SCANS(MAX_SCANS)
   ) u_front (
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .push     (push),
      .cmd      (push_cmd)
   );

   sci_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .pop     (pop),
      .q_valid (q_valid),
      .q_full  (q_full),
      .head    (head)
   );

   sci_back #(
      .LOG_DEPTH(LOG_DEPTH),
      .MAX_SCANS(MAX_SCANS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .auto_clearing(cfg_ff.auto_clearing),
      .q_valid      (q_valid),
      .cmd          (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule
